// File: src/dbwa_pkg.sv
`timescale 1ns / 1ps

package dbwa_pkg;

  localparam int unsigned WIN_W     = 16;
  localparam int unsigned DLY_W     = 24;
  localparam int unsigned WORD_W    = 64;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 24;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_MIN_WINDOW    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_SHRINK = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GROW_DELAY    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHRINK_DELAY  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_CEILING = 3'd4;

  // Reset values of the configuration registers
  localparam logic [WIN_W-1:0] RST_MIN_WINDOW    = 16'd7;
  localparam logic [DLY_W-1:0] RST_PERIOD_SHRINK = 24'd40;
  localparam logic [DLY_W-1:0] RST_GROW_DELAY    = 24'd20;
  localparam logic [DLY_W-1:0] RST_SHRINK_DELAY  = 24'd100;
  localparam logic [DLY_W-1:0] RST_DELAY_CEILING = 24'd80000;

  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_SHRUNK = 2'd1,
    ACT_GROWN  = 2'd2
  } action_e;

  typedef struct packed {
    logic busy;
    logic done;
  } rem_status_t;

endpackage

// File: src/dbwa_rem.sv
`timescale 1ns / 1ps

// Restoring bit-serial remainder: one dividend bit per cycle, one 17-bit
// compare/subtract shared across all steps.
module dbwa_rem
  import dbwa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [WORD_W-1:0] dividend_i,
  input  logic [WIN_W-1:0]  divisor_i,
  output rem_status_t       status_o,
  output logic [WIN_W-1:0]  rem_o
);

  localparam int unsigned CNT_W = $clog2(WORD_W);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [WORD_W-1:0] dvd_q, dvd_d;
  logic [WIN_W-1:0]  dsr_q, dsr_d;
  logic [WIN_W-1:0]  rem_q, rem_d;

  logic [WIN_W:0] trial;
  logic [WIN_W:0] diff;

  assign trial = {rem_q, dvd_q[WORD_W-1]};
  assign diff  = trial - {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(WORD_W - 1);
      dvd_d  = dividend_i;
      dsr_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      // for a nonzero divisor the remainder stays below it, so either branch fits WIN_W
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = diff[WIN_W-1:0];
      end else begin
        rem_d = trial[WIN_W-1:0];
      end
      dvd_d = {dvd_q[WORD_W-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign rem_o         = rem_q;

endmodule

// File: src/delay_based_window_adjust.sv
`timescale 1ns / 1ps

// Channel | Direction | Handshake               | Payload
// --------+-----------+-------------------------+---------------------------------
// in      | input     | in_valid_i / in_stall_o | seq_acked, send_time, recv_time
// out     | output    | out_valid_o / out_stall_i | window, action
// cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One ack goes from acceptance to a loaded output register in steps:
// the delay bands are latched at acceptance, then the bit-serial
// remainder unit runs (seq_acked mod window, one bit a cycle), then the
// periodic flag is latched, then the window update step loads the output
// register once it is free. The next ack is accepted only after that
// update step. The input stalls for the whole time; a result held in
// the output register does not block the next ack until its update step.
// Reset (async, active low) sets the window to INITIAL_WINDOW and the
// registers to their defaults. The config port is always ready.
module delay_based_window_adjust
  import dbwa_pkg::*;
#(
  parameter logic [WIN_W-1:0] INITIAL_WINDOW = 16'd20,
  parameter logic [WIN_W-1:0] MAX_WINDOW     = 16'd65535
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [WORD_W-1:0]    in_seq_acked_i,
  input  logic [WORD_W-1:0]    in_send_time_i,
  input  logic [WORD_W-1:0]    in_recv_time_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [WIN_W-1:0]     out_window_o,
  output logic [1:0]           out_action_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_UPD
  } state_e;

  state_e state_q;

  logic [WIN_W-1:0] min_window_q;
  logic [DLY_W-1:0] period_shrink_q;
  logic [DLY_W-1:0] grow_delay_q;
  logic [DLY_W-1:0] shrink_delay_q;
  logic [DLY_W-1:0] delay_ceiling_q;

  logic [WIN_W-1:0] cwnd_q;
  logic             per_shrink_q;
  logic             grow_q;
  logic             shrink_q;
  logic             periodic_q;
  logic             out_valid_q;
  logic [WIN_W-1:0] out_window_q;
  action_e          out_action_q;

  logic              in_fire;
  logic              out_free;
  logic [WORD_W-1:0] delay;
  logic              delay_hi;
  logic [DLY_W-1:0]  delay_lo;
  logic              below_ceiling;
  rem_status_t       rem_status;
  logic [WIN_W-1:0]  rem;

  logic [WIN_W-1:0] w_shr;
  logic [WIN_W-1:0] w_new;
  action_e          act_new;

  assign in_fire    = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  // delay bands: upper 40 bits nonzero puts the delay above any 24-bit bound
  assign delay         = in_recv_time_i - in_send_time_i;
  assign delay_hi      = |delay[WORD_W-1:DLY_W];
  assign delay_lo      = delay[DLY_W-1:0];
  assign below_ceiling = !delay_hi && (delay_lo < delay_ceiling_q);

  dbwa_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_fire),
    .dividend_i (in_seq_acked_i),
    .divisor_i  (cwnd_q),
    .status_o   (rem_status),
    .rem_o      (rem)
  );

  always_comb begin
    logic do_shrink;
    do_shrink = periodic_q ? per_shrink_q : shrink_q;
    w_shr     = cwnd_q;
    if (do_shrink && (cwnd_q > min_window_q) && (cwnd_q > WIN_W'(1))) begin
      w_shr = cwnd_q - 1'b1;
    end
    w_new = w_shr;
    if (periodic_q && grow_q && (w_shr < MAX_WINDOW)) begin
      w_new = w_shr + 1'b1;
    end
    if (w_new < cwnd_q) begin
      act_new = ACT_SHRUNK;
    end else if (w_new > cwnd_q) begin
      act_new = ACT_GROWN;
    end else begin
      act_new = ACT_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cwnd_q      <= INITIAL_WINDOW;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && (state_q != ST_UPD)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (rem_status.done) begin
            state_q <= ST_UPD;
          end
        end
        ST_UPD: begin
          if (out_free) begin
            cwnd_q      <= w_new;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end else begin
            out_valid_q <= 1'b1;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      per_shrink_q <= (delay_hi || (delay_lo > period_shrink_q)) && below_ceiling;
      grow_q       <= !delay_hi && (delay_lo != '0) && (delay_lo < grow_delay_q);
      shrink_q     <= (delay_hi || (delay_lo > shrink_delay_q)) && below_ceiling;
    end
    if (state_q == ST_DIV && rem_status.done) begin
      // a zero window counts as periodic
      periodic_q <= (rem == '0) || (cwnd_q == '0);
    end
    if (state_q == ST_UPD && out_free) begin
      out_window_q <= w_new;
      out_action_q <= act_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_window_q    <= RST_MIN_WINDOW;
      period_shrink_q <= RST_PERIOD_SHRINK;
      grow_delay_q    <= RST_GROW_DELAY;
      shrink_delay_q  <= RST_SHRINK_DELAY;
      delay_ceiling_q <= RST_DELAY_CEILING;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_MIN_WINDOW:    min_window_q    <= cfg_data_i[WIN_W-1:0];
        REG_PERIOD_SHRINK: period_shrink_q <= cfg_data_i;
        REG_GROW_DELAY:    grow_delay_q    <= cfg_data_i;
        REG_SHRINK_DELAY:  shrink_delay_q  <= cfg_data_i;
        REG_DELAY_CEILING: delay_ceiling_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_ready_o  = 1'b1;
  assign out_valid_o  = out_valid_q;
  assign out_window_o = out_window_q;
  assign out_action_o = out_action_q;

`ifndef SYNTHESIS
  a_window_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_window_o != '0))
    else $error("window reported as zero");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (in_stall_o && rem_status.busy))
    else $error("remainder unit not started on accepted transaction");

  a_action_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_action_o == ACT_NONE || out_action_o == ACT_SHRUNK ||
                     out_action_o == ACT_GROWN))
    else $error("undefined action code");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_status.done |-> (state_q == ST_DIV))
    else $error("remainder done outside divide state");
`endif

endmodule
